// ----- rtl/core/mgpc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mgpc_pkg;

   // widths fixed by the transaction fields
   localparam int ELEM_W  = 10;
   localparam int COUNT_W = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // command codes
   localparam logic CMD_REMOVE = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   // one tree node: every leaf below is present, and the saturated count sum
   typedef struct packed {
      logic               full;
      logic [COUNT_W-1:0] sum;
   } node_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LEAF_RD,
      ST_LEAF_WR,
      ST_UP_RD,
      ST_UP_WR,
      ST_ROOT_RD,
      ST_ROOT_CHK,
      ST_DN_RD,
      ST_DN_CHK,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/core/multiset_gap_prefix_counter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake          payload
// req      in         req_valid/stall    req_command, req_element_value
// rsp      out        rsp_valid/stall    rsp_count_below_gap
//
// L = clog2(min(VALUE_COUNT, 1024)): the tree memory is walked level by level,
// up with a read and a write step per level to update a valid value, then down
// with a read and a check step per level to search, unless the root is full.
// after reset a clearing pass over all 2^(L+1) rows runs with req_stall high.
// a finished result sits in the rsp register; while it waits, the next
// transaction is accepted and a stalled rsp holds it only in its last step.

module multiset_gap_prefix_counter
   import mgpc_pkg::*;
#(
   parameter int VALUE_COUNT = 1024
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire                 req_command,
   input  wire  [ELEM_W-1:0]   req_element_value,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic [COUNT_W-1:0]  rsp_count_below_gap
);

   // values at or above 2^ELEM_W never reach the tree
   localparam int EFF_COUNT = (VALUE_COUNT < (1 << ELEM_W)) ? VALUE_COUNT : (1 << ELEM_W);
   localparam int LEVELS    = $clog2(EFF_COUNT);
   localparam int AW        = LEVELS + 1;
   localparam int DEPTH     = 1 << AW;

   localparam logic [AW-1:0] ROOT_IDX  = AW'(1);
   localparam logic [AW-1:0] LEAF0_IDX = AW'(1 << LEVELS);

   // tree memory, node 1 is the root, leaves at 2^LEVELS + value
   node_type tree_mem [DEPTH];

   state_type         state_ff, state_in;
   logic [AW-1:0]     node_ff, node_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   node_type          cur_ff, cur_in;
   logic [COUNT_W-1:0] acc_ff, acc_in;
   logic              cmd_ff, cmd_in;
   node_type          rd_data_ff;
   logic              rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_data_ff;

   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   node_type          mem_wdata;
   logic              rsp_load;

   // shared arithmetic unit: saturating add, or decrement that stops at zero
   logic [COUNT_W-1:0] alu_a, alu_b, alu_y;
   logic               alu_dec;
   logic [COUNT_W:0]   alu_sum;

   logic              req_accept;
   logic              value_ok;
   logic [AW-1:0]     leaf_idx;

   assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b};

   always_comb begin
      if (alu_dec) begin
         alu_y = (alu_a == '0) ? '0 : alu_sum[COUNT_W-1:0];
      end else begin
         alu_y = alu_sum[COUNT_W] ? COUNT_MAX : alu_sum[COUNT_W-1:0];
      end
   end

   // input decode
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign value_ok   = (req_element_value != '0) &&
                       (32'(req_element_value) < 32'(VALUE_COUNT));
   assign leaf_idx   = {1'b1, req_element_value[LEVELS-1:0]};

   // sequencer
   always_comb begin
      state_in    = state_ff;
      node_in     = node_ff;
      clr_addr_in = clr_addr_ff;
      cur_in      = cur_ff;
      acc_in      = acc_ff;
      cmd_in      = cmd_ff;
      mem_we      = 1'b0;
      mem_waddr   = node_ff;
      mem_wdata   = cur_ff;
      mem_re      = 1'b0;
      mem_raddr   = node_ff;
      alu_a       = acc_ff;
      alu_b       = rd_data_ff.sum;
      alu_dec     = 1'b0;
      rsp_load    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we         = 1'b1;
            mem_waddr      = clr_addr_ff;
            mem_wdata.full = (clr_addr_ff == LEAF0_IDX);
            mem_wdata.sum  = '0;
            clr_addr_in    = clr_addr_ff + AW'(1);
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in  = req_command;
               node_in = leaf_idx;
               state_in = value_ok ? ST_LEAF_RD : ST_ROOT_RD;
            end
         end
         ST_LEAF_RD: begin
            mem_re    = 1'b1;
            mem_raddr = node_ff;
            state_in  = ST_LEAF_WR;
         end
         ST_LEAF_WR: begin
            // new copy count of the leaf
            alu_a          = rd_data_ff.sum;
            alu_b          = (cmd_ff == CMD_INSERT) ? COUNT_W'(1) : COUNT_MAX;
            alu_dec        = (cmd_ff == CMD_REMOVE);
            cur_in.full    = (alu_y != '0);
            cur_in.sum     = alu_y;
            mem_we         = 1'b1;
            mem_waddr      = node_ff;
            mem_wdata      = cur_in;
            state_in       = ST_UP_RD;
         end
         ST_UP_RD: begin
            if (node_ff == ROOT_IDX) begin
               state_in = ST_ROOT_RD;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = node_ff ^ AW'(1);
               state_in  = ST_UP_WR;
            end
         end
         ST_UP_WR: begin
            // parent from the updated node and its sibling
            alu_a       = cur_ff.sum;
            alu_b       = rd_data_ff.sum;
            cur_in.full = cur_ff.full && rd_data_ff.full;
            cur_in.sum  = alu_y;
            node_in     = node_ff >> 1;
            mem_we      = 1'b1;
            mem_waddr   = node_in;
            mem_wdata   = cur_in;
            state_in    = ST_UP_RD;
         end
         ST_ROOT_RD: begin
            mem_re    = 1'b1;
            mem_raddr = ROOT_IDX;
            state_in  = ST_ROOT_CHK;
         end
         ST_ROOT_CHK: begin
            if (rd_data_ff.full) begin
               acc_in   = rd_data_ff.sum;
               state_in = ST_OUT;
            end else begin
               acc_in   = '0;
               node_in  = ROOT_IDX;
               state_in = ST_DN_RD;
            end
         end
         ST_DN_RD: begin
            if (node_ff[AW-1]) begin
               // reached the leaf of the smallest absent value
               state_in = ST_OUT;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = {node_ff[AW-2:0], 1'b0};
               state_in  = ST_DN_CHK;
            end
         end
         ST_DN_CHK: begin
            // full left subtree: count it and go right
            if (rd_data_ff.full) begin
               alu_a   = acc_ff;
               alu_b   = rd_data_ff.sum;
               acc_in  = alu_y;
               node_in = {node_ff[AW-2:0], 1'b1};
            end else begin
               node_in = {node_ff[AW-2:0], 1'b0};
            end
            state_in = ST_DN_RD;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // tree memory ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tree_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= tree_mem[mem_raddr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      node_ff <= node_in;
      cur_ff  <= cur_in;
      acc_ff  <= acc_in;
      cmd_ff  <= cmd_in;
      if (rsp_load) begin
         rsp_data_ff <= acc_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_count_below_gap = rsp_data_ff;

   // no transaction is taken during the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> req_stall)
      else $error("transaction accepted while clearing");

   // an accepted transaction always starts the sequencer
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != ST_IDLE))
      else $error("sequencer did not start");

   // the leaf write hits the leaf row of the tree
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEAF_WR) |-> (mem_we && mem_waddr[AW-1]))
      else $error("leaf write outside leaf row");

   // a result appears only from the final sequencer step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result without finished search");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import mgpc_pkg::*;

   localparam int VALUES        = 1024;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 100;

   // predicted copy counts and the queue of count_below_gap values still to come
   class gap_prefix_board;
      logic [COUNT_W-1:0] copies [VALUES];
      logic [COUNT_W-1:0] expected_counts [$];
      int failures;

      function new();
         foreach (copies[v]) copies[v] = '0;
         failures = 0;
      endfunction

      // smallest positive value with no copies, VALUES when none is missing
      function int first_gap();
         for (int v = 1; v < VALUES; v++) begin
            if (copies[v] == '0) return v;
         end
         return VALUES;
      endfunction

      function int pending();
         return expected_counts.size();
      endfunction

      // accepted input transaction: update the multiset, predict the result
      function void note_item(logic cmd, logic [ELEM_W-1:0] val);
         longint unsigned total;
         total = 0;
         if (val != '0 && int'(val) < VALUES) begin
            if (cmd == CMD_INSERT) begin
               if (copies[val] != COUNT_MAX) copies[val] = copies[val] + 1'b1;
            end else if (copies[val] != '0) begin
               copies[val] = copies[val] - 1'b1;
            end
         end
         for (int v = 1; v < VALUES; v++) begin
            if (copies[v] == '0) break;
            total += copies[v];
            if (total > COUNT_MAX) total = COUNT_MAX;
         end
         expected_counts.push_back(total[COUNT_W-1:0]);
      endfunction

      // accepted result transaction: compare with the oldest prediction
      function void check_result(logic [COUNT_W-1:0] got);
         logic [COUNT_W-1:0] want;
         if (expected_counts.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: count_below_gap %0d arrived with nothing pending", $time, got);
         end else begin
            want = expected_counts.pop_front();
            if (got !== want) begin
               failures++;
               if (failures <= 10)
                  $display("%0t: count_below_gap expected %0d, actual %0d", $time, want, got);
            end
         end
      endfunction
   endclass

   logic              clock             = 1'b0;
   logic              reset             = 1'b1;
   logic              req_valid         = 1'b0;
   logic              req_command       = CMD_REMOVE;
   logic [ELEM_W-1:0] req_element_value = '0;
   logic              rsp_stall         = 1'b0;
   wire               req_stall;
   wire               rsp_valid;
   wire [COUNT_W-1:0] rsp_count_below_gap;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_request  = 0;
   int hold_left     = 0;

   gap_prefix_board board;

   multiset_gap_prefix_counter #(
      .VALUE_COUNT(VALUES)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_element_value  (req_element_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_count_below_gap(rsp_count_below_gap)
   );

   always #1 clock = ~clock;

   // receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // both channels sampled mid-cycle, where everything is settled
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_item(req_command, req_element_value);
         if (rsp_valid && !rsp_stall) board.check_result(rsp_count_below_gap);
      end
   end

   // offer one transaction, returns at the edge where it is taken
   task automatic send_item(input logic cmd, input logic [ELEM_W-1:0] val);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_element_value <= val;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
   endtask

   // mostly moves around the current gap, with some holes, repeats and noise
   task automatic send_random_item();
      int               gap;
      int               pick;
      int               near;
      logic             cmd;
      logic [ELEM_W-1:0] val;
      gap  = board.first_gap();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         near = gap - 1 + int'($urandom_range(0, 3));
         if (near < 1) near = 1;
         if (near > VALUES - 1) near = VALUES - 1;
         cmd = CMD_INSERT;
         val = ELEM_W'(near);
      end else if (pick < 65) begin
         cmd = CMD_REMOVE;
         val = ELEM_W'($urandom_range(1, (gap > 1) ? gap - 1 : 1));
      end else if (pick < 80) begin
         cmd = CMD_INSERT;
         val = ELEM_W'($urandom_range(1, 40));
      end else if (pick < 95) begin
         cmd = ($urandom_range(0, 1) != 0) ? CMD_INSERT : CMD_REMOVE;
         val = ELEM_W'($urandom_range(0, VALUES - 1));
      end else begin
         cmd = ($urandom_range(0, 1) != 0) ? CMD_INSERT : CMD_REMOVE;
         val = '0;
      end
      send_item(cmd, val);
   endtask

   // stop offering and wait for every outstanding result
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: absent removes, value zero, duplicates, extremes of the value field
      send_item(CMD_REMOVE, 10'd1);
      send_item(CMD_INSERT, 10'd0);
      send_item(CMD_REMOVE, 10'd0);
      send_item(CMD_INSERT, 10'd2);
      send_item(CMD_INSERT, 10'd1);
      send_item(CMD_INSERT, 10'd1);
      send_item(CMD_INSERT, 10'd3);
      send_item(CMD_REMOVE, 10'd2);
      send_item(CMD_REMOVE, 10'd2);
      send_item(CMD_INSERT, 10'd2);
      send_item(CMD_INSERT, 10'd1023);
      send_item(CMD_INSERT, 10'd682);
      send_item(CMD_INSERT, 10'd341);
      send_item(CMD_REMOVE, 10'd1023);
      send_item(CMD_REMOVE, 10'd1023);
      send_item(CMD_INSERT, 10'd4);
      send_item(CMD_REMOVE, 10'd1);
      send_item(CMD_REMOVE, 10'd1);
      send_item(CMD_REMOVE, 10'd1);
      send_item(CMD_INSERT, 10'd1);
      drain();

      // no idling, receiver holds off long enough to back up the input
      hold_request = HOLD_CYCLES;
      repeat (250) send_random_item();
      drain();

      // sender idling: fill every missing value so no gap is left, then mix
      send_idle_pct = 45;
      for (int v = 1; v < VALUES; v++) begin
         if (board.copies[v] == '0) send_item(CMD_INSERT, ELEM_W'(v));
      end
      repeat (100) send_random_item();
      drain();

      // receiver stalling
      send_idle_pct = 0;
      stall_pct     = 45;
      repeat (250) send_random_item();
      drain();

      // both sides idling
      send_idle_pct = 30;
      stall_pct     = 30;
      repeat (250) send_random_item();
      drain();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.pending() != 0)
         $display("%0d results never arrived", board.pending());
      if (board.failures == 0 && board.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog
   initial begin
      #3000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
